// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the vector norm block.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define VNE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("vne: property violated");
`define VNE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("vne: forbidden condition seen");
`else
`define VNE_ASSERT(lbl, clk, rst_n, prop)
`define VNE_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== hw/rtl/vne_pkg.sv =====
// Types and constants of the vector norm and extreme reduction block.
// No dependencies; used by every module of the block.
`default_nettype none

package vne_pkg;

  localparam int IdxW     = 20;
  localparam int ValW     = 24;
  localparam int MagW     = 24;
  localparam int GapW     = 25;
  localparam int ProdW    = 47;
  localparam int AbsW     = 36;
  localparam int SqW      = 59;
  localparam int InDataW  = 48;
  localparam int OutDataW = 184;
  localparam int AddrW    = 3;
  localparam int ApbDataW = 32;

  localparam logic RegNearestTarget = 1'b0;

  localparam logic [AbsW-1:0] AbsMax = {AbsW{1'b1}};
  localparam logic [SqW-1:0]  SqMax  = {SqW{1'b1}};

  typedef struct packed {
    logic                   last;
    logic signed [ValW-1:0] value;
    logic [IdxW-1:0]        index;
  } entry_t;

  typedef struct packed {
    logic             last;
    logic [IdxW-1:0]  index;
    logic [MagW-1:0]  mag;
    logic [ProdW-1:0] square;
    logic [GapW-1:0]  gap;
  } prep_t;

  typedef struct packed {
    logic [IdxW-1:0] nearest_idx;
    logic [IdxW-1:0] smallest_idx;
    logic [IdxW-1:0] largest_idx;
    logic [MagW-1:0] largest_abs;
    logic [SqW-1:0]  square_sum;
    logic [AbsW-1:0] abs_sum;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vne_skid.sv =====
// Input skid buffer and input register of the vector norm block.
// Depends on vne_pkg.
`default_nettype none

module vne_skid import vne_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   advance_i,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  wire entry_t in_word_i,
  output logic        out_valid_o,
  output entry_t      out_word_o
);

  logic   skid_valid_q, skid_valid_d;
  entry_t skid_word_q;
  logic   stage_valid_q, stage_valid_d;
  entry_t stage_word_q;
  logic   take;

  assign in_ready_o = !skid_valid_q;
  assign take       = in_valid_i && !skid_valid_q;

  always_comb begin
    skid_valid_d  = skid_valid_q;
    stage_valid_d = stage_valid_q;
    if (advance_i) begin
      skid_valid_d  = 1'b0;
      stage_valid_d = skid_valid_q || take;
    end else if (take) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q  <= 1'b0;
      stage_valid_q <= 1'b0;
    end else begin
      skid_valid_q  <= skid_valid_d;
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!advance_i && take) begin
      skid_word_q <= in_word_i;
    end
    if (advance_i) begin
      stage_word_q <= skid_valid_q ? skid_word_q : in_word_i;
    end
  end

  assign out_valid_o = stage_valid_q;
  assign out_word_o  = stage_word_q;

endmodule

`default_nettype wire

// ===== hw/rtl/vne_prep.sv =====
// Magnitude, square and target distance of one word, registered.
// Depends on vne_pkg.
`default_nettype none

module vne_prep import vne_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   advance_i,
  input  wire logic signed [ValW-1:0] target_i,
  input  wire logic                   in_valid_i,
  input  wire entry_t                 in_word_i,
  output logic                        out_valid_o,
  output prep_t                       out_word_o
);

  logic             valid_q;
  prep_t            word_q, word_d;
  logic [MagW-1:0]  mag;
  logic [GapW-1:0]  diff;

  always_comb begin
    mag  = in_word_i.value[ValW-1] ? (~in_word_i.value + MagW'(1)) : in_word_i.value;
    diff = {in_word_i.value[ValW-1], in_word_i.value} - {target_i[ValW-1], target_i};
    word_d.last   = in_word_i.last;
    word_d.index  = in_word_i.index;
    word_d.mag    = mag;
    word_d.square = {{(ProdW-MagW){1'b0}}, mag} * {{(ProdW-MagW){1'b0}}, mag};
    word_d.gap    = diff[GapW-1] ? (~diff + GapW'(1)) : diff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

// ===== hw/rtl/vne_reduce.sv =====
// Running sums and extremes of one vector, and the result register.
// Depends on vne_pkg.
`default_nettype none

module vne_reduce import vne_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  advance_i,
  input  wire logic  in_valid_i,
  input  wire prep_t in_word_i,
  output logic       out_valid_o,
  output result_t    out_word_o
);

  logic [AbsW-1:0] abs_acc_q, abs_acc_d;
  logic [SqW-1:0]  sq_acc_q, sq_acc_d;
  logic [MagW-1:0] large_abs_q, large_abs_d;
  logic [IdxW-1:0] large_pos_q, large_pos_d;
  logic [MagW-1:0] small_abs_q, small_abs_d;
  logic [IdxW-1:0] small_pos_q, small_pos_d;
  logic [GapW-1:0] gap_q, gap_d;
  logic [IdxW-1:0] gap_pos_q, gap_pos_d;
  logic            first_q;
  logic [AbsW:0]   abs_sum;
  logic [SqW:0]    sq_sum;
  logic            out_valid_q;
  result_t         out_word_q, res;
  logic            step;

  assign step = advance_i && in_valid_i;

  always_comb begin
    abs_sum = {1'b0, abs_acc_q} + (AbsW+1)'(in_word_i.mag);
    sq_sum  = {1'b0, sq_acc_q} + (SqW+1)'(in_word_i.square);
    abs_acc_d = abs_sum[AbsW] ? AbsMax : abs_sum[AbsW-1:0];
    sq_acc_d  = sq_sum[SqW] ? SqMax : sq_sum[SqW-1:0];

    large_abs_d = large_abs_q;
    large_pos_d = large_pos_q;
    small_abs_d = small_abs_q;
    small_pos_d = small_pos_q;
    gap_d       = gap_q;
    gap_pos_d   = gap_pos_q;
    if (first_q || in_word_i.mag > large_abs_q) begin
      large_abs_d = in_word_i.mag;
      large_pos_d = in_word_i.index;
    end
    if (first_q || in_word_i.mag < small_abs_q) begin
      small_abs_d = in_word_i.mag;
      small_pos_d = in_word_i.index;
    end
    if (first_q || in_word_i.gap < gap_q) begin
      gap_d     = in_word_i.gap;
      gap_pos_d = in_word_i.index;
    end

    res.abs_sum      = abs_acc_d;
    res.square_sum   = sq_acc_d;
    res.largest_abs  = large_abs_d;
    res.largest_idx  = large_pos_d;
    res.smallest_idx = small_pos_d;
    res.nearest_idx  = gap_pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_acc_q   <= '0;
      sq_acc_q    <= '0;
      large_abs_q <= '0;
      large_pos_q <= '0;
      small_abs_q <= '0;
      small_pos_q <= '0;
      gap_q       <= '0;
      gap_pos_q   <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (advance_i) begin
        out_valid_q <= in_valid_i && in_word_i.last;
      end
      if (step) begin
        if (in_word_i.last) begin
          abs_acc_q   <= '0;
          sq_acc_q    <= '0;
          large_abs_q <= '0;
          large_pos_q <= '0;
          small_abs_q <= '0;
          small_pos_q <= '0;
          gap_q       <= '0;
          gap_pos_q   <= '0;
          first_q     <= 1'b1;
        end else begin
          abs_acc_q   <= abs_acc_d;
          sq_acc_q    <= sq_acc_d;
          large_abs_q <= large_abs_d;
          large_pos_q <= large_pos_d;
          small_abs_q <= small_abs_d;
          small_pos_q <= small_pos_d;
          gap_q       <= gap_d;
          gap_pos_q   <= gap_pos_d;
          first_q     <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_word_i.last) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

// ===== hw/rtl/vector_norm_extreme_reduction.sv =====
// Vector norm and extreme reduction over a stream of sparse vector entries.
// Input: one word per stored entry; tdata = {entry_value, entry_index}, tlast
// marks the final entry. Output: one word per vector, sent with tlast high,
// carrying the saturating sums of |value| and value^2, the largest |value| and
// the indices of the largest |value|, the smallest |value| and the value
// nearest the target register. Ties keep the earliest entry.
// Configuration: APB register 0 (byte address 0) holds nearest_target, signed
// Q11.12 in bits 23:0; write it only while no vector is in flight.
// Throughput: one entry per cycle while the output is not stalled, through the
// input register, the product stage and the accumulator stage.
// The last entry passes the input register and the product stage before its
// result word is registered; a stalled output holds it on the way.
// Reset clears the accumulators, the pipeline valid flags and the target.
// When the receiver stalls a waiting result, the pipeline holds; the input
// takes one more word into its skid stage and then drops tready until the
// result is taken.
// Depends on vne_pkg, vne_skid, vne_prep, vne_reduce and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vector_norm_extreme_reduction import vne_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrW-1:0]    paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0]      prdata,
  output logic                     pready,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [19:0] entry_index, [43:20] entry_value, [47:44] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  input  wire logic                s_axis_tlast,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [35:0] abs_sum, [94:36] square_sum, [118:95] largest_abs,
  // [138:119] largest_abs_index, [158:139] smallest_abs_index,
  // [178:159] closest_index, [183:179] zero
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tlast
);

  logic signed [ValW-1:0] target_q;
  logic                   advance;
  entry_t                 in_word;
  logic                   stage_valid;
  entry_t                 stage_word;
  logic                   prep_valid;
  prep_t                  prep_word;
  result_t                res;

  assign pready = 1'b1;
  assign prdata = (paddr[AddrW-1] == RegNearestTarget) ?
                  {{(ApbDataW-ValW){1'b0}}, target_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[AddrW-1] == RegNearestTarget) begin
      target_q <= pwdata[ValW-1:0];
    end
  end

  assign advance = !m_axis_tvalid || m_axis_tready;

  assign in_word.index = s_axis_tdata[IdxW-1:0];
  assign in_word.value = s_axis_tdata[IdxW+ValW-1:IdxW];
  assign in_word.last  = s_axis_tlast;

  vne_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_word_i   (in_word),
    .out_valid_o (stage_valid),
    .out_word_o  (stage_word)
  );

  vne_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .target_i    (target_q),
    .in_valid_i  (stage_valid),
    .in_word_i   (stage_word),
    .out_valid_o (prep_valid),
    .out_word_o  (prep_word)
  );

  vne_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .in_valid_i  (prep_valid),
    .in_word_i   (prep_word),
    .out_valid_o (m_axis_tvalid),
    .out_word_o  (res)
  );

  assign m_axis_tdata = {{(OutDataW-$bits(result_t)){1'b0}}, res};
  assign m_axis_tlast = 1'b1;

  `VNE_ASSERT(a_skid_holds, clk_i, rst_ni, (!s_axis_tready && !advance) |=> !s_axis_tready)
  `VNE_ASSERT(a_result_source, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(prep_valid && prep_word.last))
  `VNE_ASSERT_NEVER(a_sum_covers_peak, clk_i, rst_ni, m_axis_tvalid && res.abs_sum == '0 && res.largest_abs != '0)

endmodule

`default_nettype wire
